[rtl/cau_pkg.sv]
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types, codes and helper functions of the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

    typedef enum logic [2:0] {
        KIND_ADD  = 3'd0,
        KIND_SUB  = 3'd1,
        KIND_MUL  = 3'd2,
        KIND_DIV  = 3'd3,
        KIND_CONJ = 3'd4,
        KIND_EQ   = 3'd5
    } cau_kind_t;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIV0 = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    // number of quotient bits produced by the divider stages
    localparam int QBITS = 33;

    // item state carried down the divider pipeline
    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] re;
        logic [31:0] im;
        logic        eq;
        logic [1:0]  st;
        logic        dz;
        logic        big_re;
        logic        big_im;
        logic        neg_re;
        logic        neg_im;
        logic [63:0] n_re;
        logic [63:0] n_im;
        logic [63:0] den;
        logic [63:0] r_re;
        logic [63:0] r_im;
        logic [QBITS-1:0] q_re;
        logic [QBITS-1:0] q_im;
    } cau_div_t;

    // saturate a wide signed value to 32 bits, msb of result is overflow
    function automatic logic [32:0] sat66(input logic signed [65:0] v);
        logic [32:0] res;
        if (v > 66'sd2147483647)
            res = {1'b1, 32'h7fff_ffff};
        else if (v < -66'sd2147483648)
            res = {1'b1, 32'h8000_0000};
        else
            res = {1'b0, v[31:0]};
        return res;
    endfunction

    // saturate a sign and quotient magnitude, msb of result is overflow
    function automatic logic [32:0] sat_quot(input logic neg, input logic big,
                                             input logic [QBITS-1:0] q);
        logic [32:0] res;
        if (neg)
        begin
            if (big || q > 33'h0_8000_0000)
                res = {1'b1, 32'h8000_0000};
            else
                res = {1'b0, 32'(33'd0 - q)};
        end
        else
        begin
            if (big || q > 33'h0_7fff_ffff)
                res = {1'b1, 32'h7fff_ffff};
            else
                res = {1'b0, q[31:0]};
        end
        return res;
    endfunction

    // one restoring division step, msb of result is the quotient bit
    function automatic logic [64:0] div_step(input logic [63:0] r, input logic xbit,
                                             input logic [63:0] d);
        logic [64:0] t;
        logic [64:0] res;
        t = {r, xbit};
        if (t >= {1'b0, d})
        begin
            t = t - {1'b0, d};
            res = {1'b1, t[63:0]};
        end
        else
            res = {1'b0, t[63:0]};
        return res;
    endfunction

endpackage

[rtl/cau_front.sv]
// ----------------------------------------------------------------------------
// cau_front
// Three stages: products and simple ops, sums, then scaling and divider setup.
// ----------------------------------------------------------------------------
module cau_front
    import cau_pkg::*;
#(
    parameter int FRAC_BITS = 16
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         kind,
    input  logic signed [31:0] a_re,
    input  logic signed [31:0] a_im,
    input  logic signed [31:0] b_re,
    input  logic signed [31:0] b_im,
    output logic               out_valid,
    input  logic               out_ready,
    output cau_div_t           out_data
);

    localparam int SH = QBITS - FRAC_BITS;

    logic v1_reg, v2_reg, v3_reg;
    logic r1, r2, r3;

    assign r3 = !v3_reg || out_ready;
    assign r2 = !v2_reg || r3;
    assign r1 = !v1_reg || r2;
    assign in_ready = r1;
    assign out_valid = v3_reg;

    // stage 1 registers
    logic [2:0] kind1_reg;
    logic signed [63:0] arbr_reg, aibi_reg, arbi_reg, aibr_reg, brbr_reg, bibi_reg;
    logic [31:0] sre1_reg, sim1_reg;
    logic seq1_reg;
    logic [1:0] sst1_reg;

    // simple ops
    logic [32:0] sat_re, sat_im;
    logic [31:0] s_re, s_im;
    logic s_eq;
    logic [1:0] s_st;

    always_comb
    begin
        sat_re = '0;
        sat_im = '0;
        s_eq = 1'b0;
        unique case (kind)
            KIND_ADD:
            begin
                sat_re = sat66(66'(a_re) + 66'(b_re));
                sat_im = sat66(66'(a_im) + 66'(b_im));
            end
            KIND_SUB:
            begin
                sat_re = sat66(66'(a_re) - 66'(b_re));
                sat_im = sat66(66'(a_im) - 66'(b_im));
            end
            KIND_CONJ:
            begin
                sat_re = sat66(66'(a_re));
                sat_im = sat66(-66'(a_im));
            end
            KIND_EQ:
                s_eq = (a_re == b_re) && (a_im == b_im);
            default:
            begin
                sat_re = '0;
            end
        endcase
        s_re = sat_re[31:0];
        s_im = sat_im[31:0];
        s_st = (sat_re[32] || sat_im[32]) ? ST_OVF : ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (r1)
            v1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (r1 && in_valid)
        begin
            kind1_reg <= kind;
            arbr_reg  <= a_re * b_re;
            aibi_reg  <= a_im * b_im;
            arbi_reg  <= a_re * b_im;
            aibr_reg  <= a_im * b_re;
            brbr_reg  <= b_re * b_re;
            bibi_reg  <= b_im * b_im;
            sre1_reg  <= s_re;
            sim1_reg  <= s_im;
            seq1_reg  <= s_eq;
            sst1_reg  <= s_st;
        end
    end

    // stage 2 registers
    logic [2:0] kind2_reg;
    logic signed [65:0] mre_reg, mim_reg, dre_reg, dim_reg;
    logic [63:0] den2_reg;
    logic [31:0] sre2_reg, sim2_reg;
    logic seq2_reg;
    logic [1:0] sst2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (r2)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (r2 && v1_reg)
        begin
            kind2_reg <= kind1_reg;
            mre_reg   <= 66'(arbr_reg) - 66'(aibi_reg);
            mim_reg   <= 66'(arbi_reg) + 66'(aibr_reg);
            dre_reg   <= 66'(arbr_reg) + 66'(aibi_reg);
            dim_reg   <= 66'(aibr_reg) - 66'(arbi_reg);
            den2_reg  <= 64'(brbr_reg) + 64'(bibi_reg);
            sre2_reg  <= sre1_reg;
            sim2_reg  <= sim1_reg;
            seq2_reg  <= seq1_reg;
            sst2_reg  <= sst1_reg;
        end
    end

    // stage 3: multiply scaling, divider setup
    cau_div_t d3_next, d3_reg;
    logic [32:0] mul_re, mul_im;
    logic [65:0] mag_re, mag_im;

    always_comb
    begin
        mul_re = sat66(mre_reg >>> FRAC_BITS);
        mul_im = sat66(mim_reg >>> FRAC_BITS);
        mag_re = dre_reg[65] ? 66'(-dre_reg) : 66'(dre_reg);
        mag_im = dim_reg[65] ? 66'(-dim_reg) : 66'(dim_reg);
        d3_next        = '0;
        d3_next.kind   = kind2_reg;
        d3_next.neg_re = dre_reg[65];
        d3_next.neg_im = dim_reg[65];
        d3_next.n_re   = mag_re[63:0];
        d3_next.n_im   = mag_im[63:0];
        d3_next.den    = den2_reg;
        d3_next.dz     = (den2_reg == '0);
        d3_next.big_re = {33'd0, mag_re[63:0]} >= ({33'd0, den2_reg} << SH);
        d3_next.big_im = {33'd0, mag_im[63:0]} >= ({33'd0, den2_reg} << SH);
        d3_next.r_re   = mag_re[63:0] >> SH;
        d3_next.r_im   = mag_im[63:0] >> SH;
        if (kind2_reg == KIND_MUL)
        begin
            d3_next.re = mul_re[31:0];
            d3_next.im = mul_im[31:0];
            d3_next.eq = 1'b0;
            d3_next.st = (mul_re[32] || mul_im[32]) ? ST_OVF : ST_OK;
        end
        else
        begin
            d3_next.re = sre2_reg;
            d3_next.im = sim2_reg;
            d3_next.eq = seq2_reg;
            d3_next.st = sst2_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (r3)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (r3 && v2_reg)
            d3_reg <= d3_next;
    end

    assign out_data = d3_reg;

endmodule

[rtl/cau_div_stage.sv]
// ----------------------------------------------------------------------------
// cau_div_stage
// One registered restoring division step for both result parts.
// ----------------------------------------------------------------------------
module cau_div_stage
    import cau_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int IDX       = 0
)(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  cau_div_t in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output cau_div_t out_data
);

    logic v_reg;
    cau_div_t d_next, d_reg;
    logic xb_re, xb_im;
    logic [64:0] st_re, st_im;

    // dividend bit: numerator scaled up by the fraction bits
    generate
        if (IDX >= FRAC_BITS)
        begin : g_bit
            assign xb_re = in_data.n_re[IDX-FRAC_BITS];
            assign xb_im = in_data.n_im[IDX-FRAC_BITS];
        end
        else
        begin : g_zero
            assign xb_re = 1'b0;
            assign xb_im = 1'b0;
        end
    endgenerate

    always_comb
    begin
        st_re = div_step(in_data.r_re, xb_re, in_data.den);
        st_im = div_step(in_data.r_im, xb_im, in_data.den);
        d_next      = in_data;
        d_next.r_re = st_re[63:0];
        d_next.r_im = st_im[63:0];
        d_next.q_re = {in_data.q_re[QBITS-2:0], st_re[64]};
        d_next.q_im = {in_data.q_im[QBITS-2:0], st_im[64]};
    end

    assign in_ready  = !v_reg || out_ready;
    assign out_valid = v_reg;
    assign out_data  = d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (in_ready)
            v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            d_reg <= d_next;
    end

endmodule

[rtl/complex_arithmetic_unit.sv]
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Pipelined complex add, subtract, multiply, divide, conjugate and compare
// on signed fixed point operands.
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid / in_stall with kind, a_re, a_im, b_re, b_im;
//   a transaction moves when in_valid is high and in_stall is low
//   output channel: out_valid / out_stall with res_re, res_im, equal, status
//   every operation goes through the same pipeline, so results leave in order
//   path: three front stages, 33 divider stages, one output register,
//   the same for all kinds
//   throughput: one transaction per cycle while no stall holds the pipeline;
//   the divide pipeline produces one quotient bit per stage, hence 33 divider stages
//   stall: each stage holds its item only while the stage after it is full
//   and stalled, so bubbles close up and an item can be accepted while a
//   finished result waits at the output
//   reset: all valid bits clear, no result pending, in_stall low
// ----------------------------------------------------------------------------
module complex_arithmetic_unit
    import cau_pkg::*;
#(
    parameter int FRAC_BITS = 16
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         kind,
    input  logic signed [31:0] a_re,
    input  logic signed [31:0] a_im,
    input  logic signed [31:0] b_re,
    input  logic signed [31:0] b_im,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] res_re,
    output logic signed [31:0] res_im,
    output logic               equal,
    output logic [1:0]         status
);

    // pipeline links: index 0 is the front end output, QBITS the last step
    cau_div_t link_data  [QBITS+1];
    logic     link_valid [QBITS+1];
    logic     link_ready [QBITS+1];
    logic     front_ready;

    cau_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (front_ready),
        .kind      (kind),
        .a_re      (a_re),
        .a_im      (a_im),
        .b_re      (b_re),
        .b_im      (b_im),
        .out_valid (link_valid[0]),
        .out_ready (link_ready[0]),
        .out_data  (link_data[0])
    );

    assign in_stall = !front_ready;

    // divider steps, most significant quotient bit first
    genvar g;
    generate
        for (g = 0; g < QBITS; g++)
        begin : g_div
            cau_div_stage #(
                .FRAC_BITS (FRAC_BITS),
                .IDX       (QBITS - 1 - g)
            ) u_step (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (link_valid[g]),
                .in_ready  (link_ready[g]),
                .in_data   (link_data[g]),
                .out_valid (link_valid[g+1]),
                .out_ready (link_ready[g+1]),
                .out_data  (link_data[g+1])
            );
        end
    endgenerate

    // output register: pick divide result or the value from the front end
    cau_div_t last;
    logic [32:0] q_re, q_im;
    logic [31:0] re_next, im_next;
    logic eq_next;
    logic [1:0] st_next;
    logic out_valid_reg;
    logic [31:0] re_reg, im_reg;
    logic eq_reg;
    logic [1:0] st_reg;

    assign last = link_data[QBITS];

    always_comb
    begin
        q_re = sat_quot(last.neg_re, last.big_re, last.q_re);
        q_im = sat_quot(last.neg_im, last.big_im, last.q_im);
        re_next = last.re;
        im_next = last.im;
        eq_next = last.eq;
        st_next = last.st;
        if (last.kind == KIND_DIV)
        begin
            eq_next = 1'b0;
            if (last.dz)
            begin
                // zero divisor gives zero parts
                re_next = '0;
                im_next = '0;
                st_next = ST_DIV0;
            end
            else
            begin
                re_next = q_re[31:0];
                im_next = q_im[31:0];
                st_next = (q_re[32] || q_im[32]) ? ST_OVF : ST_OK;
            end
        end
    end

    assign link_ready[QBITS] = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (link_ready[QBITS])
            out_valid_reg <= link_valid[QBITS];
    end

    always_ff @(posedge clk)
    begin
        if (link_ready[QBITS] && link_valid[QBITS])
        begin
            re_reg <= re_next;
            im_reg <= im_next;
            eq_reg <= eq_next;
            st_reg <= st_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign res_re    = re_reg;
    assign res_im    = im_reg;
    assign equal     = eq_reg;
    assign status    = st_reg;

    // a zero divisor result carries zero parts
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_DIV0 |-> res_re == '0 && res_im == '0)
        else $error("divide by zero result not zero");

    // an equality hit never reports a status or parts
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && equal |-> status == ST_OK && res_re == '0 && res_im == '0)
        else $error("equality result carries parts or status");

    // status code 3 is never produced
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status != 2'd3)
        else $error("undefined status code");

    // a stalled result at the output holds the stage behind it back
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> !link_ready[QBITS])
        else $error("output stage accepts while stalled");

endmodule
